/* design/gauss_jordan_linear_solver_defines.svh */
// Assertion macros used by the checker file.
`ifndef GAUSS_JORDAN_LINEAR_SOLVER_DEFINES_SVH
`define GAUSS_JORDAN_LINEAR_SOLVER_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define GJ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define GJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/gjls_pkg.sv */
// Package with types, constants and arithmetic helpers of the solver.
package gjls_pkg;
  localparam int unsigned MaxUnknowns = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;

  localparam logic [1:0] StatusDetermined   = 2'd0;
  localparam logic [1:0] StatusIndeterminate = 2'd1;
  localparam logic [1:0] StatusIncompatible = 2'd2;

  localparam logic CfgSize = 1'b0;
  localparam logic CfgTol  = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_WAIT,
    S_PIV_CHK,
    S_SRCH_RD,
    S_SRCH_WAIT,
    S_SRCH_CHK,
    S_SWAP_RDA,
    S_SWAP_RDB,
    S_SWAP_WAIT,
    S_SWAP_WRA,
    S_SWAP_WRB,
    S_CLR_WR,
    S_ROW_RD,
    S_ROW_WAIT,
    S_DIV,
    S_ELM_RDA,
    S_ELM_RDB,
    S_ELM_WAIT,
    S_ELM_MUL,
    S_ELM_WR,
    S_BS_INIT,
    S_BS_RDA,
    S_BS_RDB,
    S_BS_WAIT,
    S_BS_MUL,
    S_BS_ACC,
    S_BS_DIAG,
    S_BS_DIV,
    S_EMIT
  } gjls_state_e;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction
endpackage

/* design/gjls_stream_if.sv */
// Valid/ready stream interface.
interface gjls_stream_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/gjls_ram.sv */
// Generic single-port RAM with a registered read.
module gjls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/gjls_divider.sv */
// Sequential signed divider: (a << 16) / b, truncated, saturated.
module gjls_divider import gjls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  localparam int unsigned NumW = 48;
  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] qt_q, qt_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [NumW-1:0] nabs;
  logic [NumW:0]   trial;
  logic [NumW-1:0] shifted;
  logic signed [63:0] res;

  always_comb begin
    nabs = num_i[31] ? NumW'(-{{16{num_i[31]}}, num_i}) : NumW'({16'd0, num_i});
    nabs = nabs << FracW;
    shifted = {rem_q[NumW-2:0], qt_q[NumW-1]};
    trial = {1'b0, shifted} - {17'd0, den_q};
    rem_d = rem_q; qt_d = qt_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      qt_d = nabs;
      den_d = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d = num_i[31] ^ den_i[31];
      cnt_d = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[NumW]) begin
        rem_d = trial[NumW-1:0];
        qt_d = {qt_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        qt_d = {qt_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qt_q <= qt_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  always_comb begin
    res = neg_q ? -$signed({16'd0, qt_q}) : $signed({16'd0, qt_q});
    quot_o = sat32(res);
  end
  assign done_o = done_q;
endmodule

/* design/gjls_datapath.sv */
// Datapath: matrix memory, working registers, multiplier and divider.
module gjls_datapath import gjls_pkg::*; #(
  parameter int unsigned MaxN = MaxUnknowns
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [$clog2(MaxN*(MaxN+1))-1:0] addr_i,
  input  logic               we_i,
  input  logic [1:0]         wsel_i,
  input  logic signed [31:0] in_elem_i,
  input  logic               lat_a_i,
  input  logic               lat_b_i,
  input  logic               lat_piv_i,
  input  logic               lat_f_i,
  input  logic               mul_fb_i,
  input  logic               mul_sol_i,
  input  logic               lat_prod_i,
  input  logic               acc_clr_i,
  input  logic               acc_add_i,
  input  logic               div_elim_i,
  input  logic               div_bs_i,
  input  logic               sol_we_i,
  input  logic               sol_zero_i,
  input  logic [$clog2(MaxN)-1:0] sol_idx_i,
  input  logic [15:0]        tol_i,
  output logic signed [31:0] rdata_o,
  output logic               div_done_o,
  output logic               tol_ok_o,
  output logic signed [31:0] sol_o
);
  localparam int unsigned Depth = MaxN * (MaxN + 1);
  logic signed [31:0] rdata;
  logic signed [31:0] a_q, b_q, piv_q, f_q, prod_q, acc_q, diff;
  logic signed [31:0] wdata, quot, dnum, dden;
  logic signed [63:0] pfull;
  logic signed [31:0] sol_q [MaxN];
  logic signed [32:0] mag;

  always_comb begin
    unique case (wsel_i)
      2'd0: wdata = in_elem_i;
      2'd1: wdata = a_q;
      2'd2: wdata = b_q;
      default: wdata = sat32(64'(a_q) - 64'(prod_q));
    endcase
  end

  gjls_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i, .addr_i, .wdata_i(wdata), .rdata_o(rdata)
  );

  assign diff = sat32(64'(a_q) - 64'(acc_q));
  // The elimination factor starts from the column word while it is on the read port.
  assign dnum = div_bs_i ? diff : rdata;
  assign dden = piv_q;

  gjls_divider u_div (
    .clk_i, .rst_ni, .start_i(div_elim_i | div_bs_i),
    .num_i(dnum), .den_i(dden), .done_o(div_done_o), .quot_o(quot)
  );

  // Floor of the product shifted by the fraction width is an arithmetic shift.
  assign pfull = (mul_sol_i ? 64'(b_q) : 64'(f_q)) * (mul_sol_i ? 64'(sol_q[sol_idx_i])
                 : 64'(b_q));

  always_ff @(posedge clk_i) begin
    if (lat_a_i) a_q <= rdata;
    if (lat_b_i) b_q <= rdata;
    if (lat_piv_i) piv_q <= rdata;
    if (lat_f_i) f_q <= quot;
    if (lat_prod_i) prod_q <= sat32(pfull >>> FracW);
    if (acc_clr_i) acc_q <= '0;
    else if (acc_add_i) acc_q <= sat32(64'(acc_q) + 64'(prod_q));
    if (sol_we_i) sol_q[sol_idx_i] <= sol_zero_i ? 32'sd0 : quot;
  end

  assign mag = diff[31] ? -33'(diff) : 33'(diff);
  assign tol_ok_o = mag < $signed({17'd0, tol_i});
  assign rdata_o = rdata;
  assign sol_o = sol_q[sol_idx_i];
  logic unused;
  assign unused = mul_fb_i;
endmodule

/* design/gjls_ctrl.sv */
// Controller state machine sequencing load, elimination and back substitution.
module gjls_ctrl import gjls_pkg::*; #(
  parameter int unsigned MaxN = MaxUnknowns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_var_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o,
  output logic [$clog2(MaxN*(MaxN+1))-1:0] addr_o,
  output logic        we_o,
  output logic [1:0]  wsel_o,
  output logic        lat_a_o,
  output logic        lat_b_o,
  output logic        lat_piv_o,
  output logic        lat_f_o,
  output logic        mul_fb_o,
  output logic        mul_sol_o,
  output logic        lat_prod_o,
  output logic        acc_clr_o,
  output logic        acc_add_o,
  output logic        div_elim_o,
  output logic        div_bs_o,
  output logic        sol_we_o,
  output logic        sol_zero_o,
  output logic [$clog2(MaxN)-1:0] sol_idx_o,
  input  logic signed [31:0] rdata_i,
  input  logic        div_done_i,
  input  logic        tol_ok_i
);
  localparam int unsigned IW = $clog2(MaxN);
  localparam int unsigned AW = $clog2(MaxN*(MaxN+1));
  localparam int unsigned CW = $clog2(MaxN+2);

  gjls_state_e st_q, st_d;
  logic [3:0]    size_q, size_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [CW-1:0] r_q, r_d, c_q, c_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] n;
  logic [3:0]    ord_q [MaxN];
  logic [3:0]    ord_d [MaxN];
  logic [1:0]    kind_q, kind_d;
  logic          inc_q, inc_d;
  logic [CW-1:0] eo_q, eo_d;
  logic [AW:0]   total;

  always_comb begin
    if (size_q == 4'd0) n = CW'(1);
    else if (32'(size_q) > MaxN) n = CW'(MaxN);
    else n = CW'(size_q);
    total = (AW+1)'(32'(n) * (32'(n) + 1));
  end

  function automatic logic [AW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * (MaxN + 1) + 32'(c));
  endfunction

  // Next-state and register update.
  always_comb begin
    st_d = st_q; size_d = size_q; cnt_d = cnt_q; r_d = r_q; c_d = c_q;
    i_d = i_q; j_d = j_q; k_d = k_q; ord_d = ord_q; kind_d = kind_q;
    inc_d = inc_q; eo_d = eo_q;
    unique case (st_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (c_q == n) begin c_d = '0; r_d = r_q + CW'(1); end
          else c_d = c_q + CW'(1);
          cnt_d = cnt_q + 1'b1;
          if (cnt_q + 1'b1 == total) begin
            st_d = S_PIV_RD; i_d = '0;
          end
        end
      end
      S_PIV_RD: st_d = S_PIV_WAIT;
      S_PIV_WAIT: st_d = S_PIV_CHK;
      S_PIV_CHK: begin
        if (rdata_i != 0) begin st_d = S_ROW_RD; j_d = '0; end
        else begin j_d = i_q + CW'(1); st_d = S_SRCH_RD; end
      end
      S_SRCH_RD: begin
        if (j_q >= n) begin st_d = S_CLR_WR; k_d = '0; end
        else st_d = S_SRCH_WAIT;
      end
      S_SRCH_WAIT: st_d = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (rdata_i != 0) begin
          st_d = S_SWAP_RDA; k_d = '0;
          ord_d[i_q[IW-1:0]] = ord_q[j_q[IW-1:0]];
          ord_d[j_q[IW-1:0]] = ord_q[i_q[IW-1:0]];
        end else begin
          j_d = j_q + CW'(1); st_d = S_SRCH_RD;
        end
      end
      S_SWAP_RDA: st_d = S_SWAP_RDB;
      S_SWAP_RDB: st_d = S_SWAP_WAIT;
      S_SWAP_WAIT: st_d = S_SWAP_WRA;
      S_SWAP_WRA: st_d = S_SWAP_WRB;
      S_SWAP_WRB: begin
        if (k_q + CW'(1) == n) st_d = S_PIV_RD;
        else begin k_d = k_q + CW'(1); st_d = S_SWAP_RDA; end
      end
      S_CLR_WR: begin
        // A cleared column has no pivot, so elimination moves to the next column.
        if (k_q + CW'(1) == n) begin
          if (i_q + CW'(1) == n) st_d = S_BS_INIT;
          else begin i_d = i_q + CW'(1); st_d = S_PIV_RD; end
        end else k_d = k_q + CW'(1);
      end
      S_ROW_RD: begin
        if (j_q == i_q) j_d = j_q + CW'(1);
        else if (j_q >= n) begin
          if (i_q + CW'(1) == n) st_d = S_BS_INIT;
          else begin i_d = i_q + CW'(1); st_d = S_PIV_RD; end
        end else st_d = S_ROW_WAIT;
      end
      S_ROW_WAIT: st_d = S_DIV;
      S_DIV: if (div_done_i) begin st_d = S_ELM_RDA; k_d = '0; end
      S_ELM_RDA: st_d = S_ELM_RDB;
      S_ELM_RDB: st_d = S_ELM_WAIT;
      S_ELM_WAIT: st_d = S_ELM_MUL;
      S_ELM_MUL: st_d = S_ELM_WR;
      S_ELM_WR: begin
        if (k_q == n) begin j_d = j_q + CW'(1); st_d = S_ROW_RD; end
        else begin k_d = k_q + CW'(1); st_d = S_ELM_RDA; end
      end
      S_BS_INIT: begin
        kind_d = StatusDetermined; inc_d = 1'b0;
        i_d = n - CW'(1); j_d = n; st_d = S_BS_RDA;
      end
      S_BS_RDA: begin
        if (j_q < n) st_d = S_BS_RDB;
        else st_d = S_BS_RDB;
      end
      S_BS_RDB: st_d = S_BS_WAIT;
      S_BS_WAIT: st_d = (j_q < n) ? S_BS_MUL : S_BS_DIAG;
      S_BS_MUL: st_d = S_BS_ACC;
      S_BS_ACC: begin j_d = j_q + CW'(1); st_d = S_BS_RDA; end
      S_BS_DIAG: begin
        if (rdata_i == 0) begin
          if (tol_ok_i) begin
            kind_d = StatusIndeterminate;
            if (i_q == '0) begin st_d = S_EMIT; eo_d = '0; end
            else begin i_d = i_q - CW'(1); j_d = i_q; st_d = S_BS_RDA; end
          end else begin
            inc_d = 1'b1; st_d = S_EMIT; eo_d = '0;
          end
        end else st_d = S_BS_DIV;
      end
      S_BS_DIV: begin
        if (div_done_i) begin
          if (i_q == '0) begin st_d = S_EMIT; eo_d = '0; end
          else begin i_d = i_q - CW'(1); j_d = i_q; st_d = S_BS_RDA; end
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (inc_q || eo_q + CW'(1) == n) begin
            st_d = S_LOAD; cnt_d = '0; r_d = '0; c_d = '0;
            for (int m = 0; m < MaxN; m++) ord_d[m] = 4'(m + 1);
          end else eo_d = eo_q + CW'(1);
        end
      end
      default: st_d = S_LOAD;
    endcase
    if (cfg_we_i && cfg_idx_i == CfgSize) begin
      size_d = cfg_size_i; st_d = S_LOAD; cnt_d = '0; r_d = '0; c_d = '0;
      for (int m = 0; m < MaxN; m++) ord_d[m] = 4'(m + 1);
    end
  end

  // Datapath commands.
  always_comb begin
    addr_o = '0; we_o = 1'b0; wsel_o = 2'd0;
    lat_a_o = 1'b0; lat_b_o = 1'b0; lat_piv_o = 1'b0; lat_f_o = 1'b0;
    mul_fb_o = 1'b0; mul_sol_o = 1'b0; lat_prod_o = 1'b0;
    acc_clr_o = 1'b0; acc_add_o = 1'b0; div_elim_o = 1'b0; div_bs_o = 1'b0;
    sol_we_o = 1'b0; sol_zero_o = 1'b0; sol_idx_o = i_q[IW-1:0];
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    out_var_o = inc_q ? 4'd0 : ord_q[eo_q[IW-1:0]];
    out_status_o = inc_q ? StatusIncompatible : kind_q;
    out_last_o = inc_q || (eo_q + CW'(1) == n);
    unique case (st_q)
      S_LOAD: begin
        in_ready_o = 1'b1; addr_o = adr(r_q, c_q); we_o = in_valid_i; wsel_o = 2'd0;
      end
      S_PIV_RD, S_PIV_WAIT: addr_o = adr(i_q, i_q);
      // A zero pivot also lands in b, which then serves as the clearing word.
      S_PIV_CHK: begin addr_o = adr(i_q, i_q); lat_piv_o = 1'b1; lat_b_o = 1'b1; end
      S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CHK: addr_o = adr(i_q, j_q);
      S_SWAP_RDA: addr_o = adr(k_q, i_q);
      S_SWAP_RDB: begin addr_o = adr(k_q, j_q); lat_a_o = 1'b1; end
      S_SWAP_WAIT: begin addr_o = adr(k_q, j_q); lat_b_o = 1'b1; end
      S_SWAP_WRA: begin addr_o = adr(k_q, i_q); we_o = 1'b1; wsel_o = 2'd2; end
      S_SWAP_WRB: begin addr_o = adr(k_q, j_q); we_o = 1'b1; wsel_o = 2'd1; end
      S_CLR_WR: begin addr_o = adr(k_q, i_q); we_o = 1'b1; wsel_o = 2'd2; end
      S_ROW_RD: addr_o = adr(j_q, i_q);
      S_ROW_WAIT: begin addr_o = adr(j_q, i_q); lat_b_o = 1'b1; div_elim_o = 1'b1; end
      S_DIV: lat_f_o = div_done_i;
      S_ELM_RDA: addr_o = adr(j_q, k_q);
      S_ELM_RDB: begin addr_o = adr(i_q, k_q); lat_a_o = 1'b1; end
      S_ELM_WAIT: begin addr_o = adr(i_q, k_q); lat_b_o = 1'b1; end
      S_ELM_MUL: begin mul_fb_o = 1'b1; lat_prod_o = 1'b1; end
      S_ELM_WR: begin addr_o = adr(j_q, k_q); we_o = 1'b1; wsel_o = 2'd3; end
      S_BS_INIT: acc_clr_o = 1'b1;
      S_BS_RDA: addr_o = (j_q < n) ? adr(i_q, j_q) : adr(i_q, n);
      S_BS_RDB: begin
        addr_o = (j_q < n) ? adr(i_q, j_q) : adr(i_q, i_q);
        if (j_q < n) lat_b_o = 1'b1; else lat_a_o = 1'b1;
      end
      S_BS_WAIT: begin
        addr_o = (j_q < n) ? adr(i_q, j_q) : adr(i_q, i_q);
        if (j_q >= n) lat_piv_o = 1'b1;
      end
      S_BS_MUL: begin
        mul_sol_o = 1'b1; lat_prod_o = 1'b1; sol_idx_o = j_q[IW-1:0];
      end
      S_BS_ACC: acc_add_o = 1'b1;
      S_BS_DIAG: begin
        addr_o = adr(i_q, i_q);
        if (rdata_i == 0) begin
          if (tol_ok_i) begin sol_we_o = 1'b1; sol_zero_o = 1'b1; acc_clr_o = 1'b1; end
        end else div_bs_o = 1'b1;
      end
      S_BS_DIV: if (div_done_i) begin sol_we_o = 1'b1; acc_clr_o = 1'b1; end
      S_EMIT: begin out_valid_o = 1'b1; sol_idx_o = eo_q[IW-1:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; size_q <= 4'd8; cnt_q <= '0; r_q <= '0; c_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; kind_q <= StatusDetermined;
      inc_q <= 1'b0; eo_q <= '0;
      for (int m = 0; m < MaxN; m++) ord_q[m] <= 4'(m + 1);
    end else begin
      st_q <= st_d; size_q <= size_d; cnt_q <= cnt_d; r_q <= r_d; c_q <= c_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; kind_q <= kind_d;
      inc_q <= inc_d; eo_q <= eo_d; ord_q <= ord_d;
    end
  end
endmodule

/* design/gauss_jordan_linear_solver.sv */
// Top level of the Gauss-Jordan linear system solver.
// Usage: configure size_in_use (index 0) and tolerance (index 1) while idle.
// Send n*(n+1) words of the augmented matrix, row-major, signed Q16.16, on
// the input channel. Input is always ready while loading.
// After the last word the block stops accepting and runs elimination on one
// shared multiply/subtract datapath with a single-port matrix memory and a
// 48-step radix-2 divider; each row update takes one division for its factor,
// then reads, multiplies, subtracts and writes back each column word in turn.
// Back substitution then uses the same multiplier and divider.
// The results, one word per unknown (or one word when incompatible), are
// offered on the output channel; the last carries last_result.
// A receiver stall holds the current word; loading of the next system starts
// after the last word is taken. Reset restores size 8, tolerance 1 and an
// empty load. Writing size_in_use restarts loading.
module gauss_jordan_linear_solver import gjls_pkg::*; #(
  parameter int unsigned MaxN = MaxUnknowns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  gjls_stream_if.sink   in_if,
  gjls_stream_if.source out_if
);
  typedef struct packed {
    logic [3:0]  variable_number;
    logic [31:0] solution_value;
    logic [1:0]  system_status;
    logic        last_result;
  } out_word_t;

  localparam int unsigned AW = $clog2(MaxN*(MaxN+1));
  logic [15:0] tol_q;
  logic [AW-1:0] addr;
  logic we, lat_a, lat_b, lat_piv, lat_f, mul_fb, mul_sol, lat_prod;
  logic acc_clr, acc_add, div_elim, div_bs, sol_we, sol_zero, div_done, tol_ok;
  logic [1:0] wsel;
  logic [$clog2(MaxN)-1:0] sol_idx;
  logic signed [31:0] rdata, sol;
  logic [3:0] ovar;
  logic [1:0] ostat;
  logic olast;
  out_word_t ow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= 16'd1;
    else if (cfg_we_i && cfg_idx_i == CfgTol) tol_q <= cfg_wdata_i;
  end

  gjls_ctrl #(.MaxN(MaxN)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]), .cfg_size_i(cfg_wdata_i[3:0]),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_var_o(ovar), .out_status_o(ostat), .out_last_o(olast),
    .addr_o(addr), .we_o(we), .wsel_o(wsel), .lat_a_o(lat_a), .lat_b_o(lat_b),
    .lat_piv_o(lat_piv), .lat_f_o(lat_f), .mul_fb_o(mul_fb), .mul_sol_o(mul_sol),
    .lat_prod_o(lat_prod), .acc_clr_o(acc_clr), .acc_add_o(acc_add),
    .div_elim_o(div_elim), .div_bs_o(div_bs), .sol_we_o(sol_we),
    .sol_zero_o(sol_zero), .sol_idx_o(sol_idx), .rdata_i(rdata),
    .div_done_i(div_done), .tol_ok_i(tol_ok)
  );

  gjls_datapath #(.MaxN(MaxN)) u_dp (
    .clk_i, .rst_ni, .addr_i(addr), .we_i(we), .wsel_i(wsel),
    .in_elem_i(in_if.data), .lat_a_i(lat_a), .lat_b_i(lat_b), .lat_piv_i(lat_piv),
    .lat_f_i(lat_f), .mul_fb_i(mul_fb), .mul_sol_i(mul_sol), .lat_prod_i(lat_prod),
    .acc_clr_i(acc_clr), .acc_add_i(acc_add), .div_elim_i(div_elim),
    .div_bs_i(div_bs), .sol_we_i(sol_we), .sol_zero_i(sol_zero), .sol_idx_i(sol_idx),
    .tol_i(tol_q), .rdata_o(rdata), .div_done_o(div_done), .tol_ok_o(tol_ok),
    .sol_o(sol)
  );

  always_comb begin
    ow.variable_number = ovar;
    ow.solution_value = (ostat == StatusIncompatible) ? 32'd0 : sol;
    ow.system_status = ostat;
    ow.last_result = olast;
  end
  assign out_if.data = ow;
endmodule

/* design/gjls_checker.sv */
// Port-level checker for the solver, bound to the top level.
`include "gauss_jordan_linear_solver_defines.svh"
module gjls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [38:0] out_data
);
  `GJ_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready,
    "input taken while results pending")
  `GJ_ASSERT_SAME(a_take_idle, clk_i, rst_ni, in_valid && in_ready, !out_valid,
    "word taken while a result is offered")
  `GJ_ASSERT_SAME(a_incompat_last, clk_i, rst_ni, out_valid && out_data[2:1] == 2'd2,
    out_data[0] && out_data[38:35] == 4'd0, "incompatible word malformed")
  `GJ_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(out_data), "stalled word changed")
endmodule

bind gauss_jordan_linear_solver gjls_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data[38:0])
);

/* tb/testbench.sv */
// Self-checking testbench for the Gauss-Jordan linear system solver.
module testbench;
  import gjls_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandomWords = 500;
  localparam int unsigned HoldOffCycles = 2000;

  typedef struct packed {
    logic [3:0]         var_num;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {ROW_SIZE, ROW_TOL, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        value;
    bit        typed;
    result_t   want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  gjls_stream_if #(.W(32)) in_if ();
  gjls_stream_if #(.W(39)) out_if ();

  gauss_jordan_linear_solver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // Solver state kept by the testbench.
  logic [3:0]  size_reg;
  logic [15:0] tol_reg;
  int          mat[8][9];
  logic [3:0]  order[8];
  int          sol[8];
  int unsigned load_cnt;
  result_t     solved[8];

  result_t     pending_q[$];
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned systems_done;
  int unsigned results_seen;
  int unsigned burst_left;
  bit          hold_req;
  stim_row_t   stim_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int fx_sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Arithmetic shift of the 64-bit product rounds toward minus infinity.
  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return fx_sat(p >>> 16);
  endfunction

  function automatic int fx_div(int a, int b);
    return fx_sat((longint'(a) <<< 16) / longint'(b));
  endfunction

  function automatic int fx_sub(int a, int b);
    return fx_sat(longint'(a) - longint'(b));
  endfunction

  function automatic int unsigned eff_n();
    if (size_reg == 4'd0) return 1;
    if (size_reg > MaxUnknowns) return MaxUnknowns;
    return size_reg;
  endfunction

  function automatic void restart_load();
    for (int i = 0; i < 8; i++) order[i] = 4'(i + 1);
    load_cnt = 0;
  endfunction

  function automatic void cfg_apply(logic idx, logic [15:0] v);
    if (idx == CfgSize) begin
      size_reg = v[3:0];
      restart_load();
    end else begin
      tol_reg = v;
    end
  endfunction

  // Stores one word; on the last word of a system solves it into solved[].
  function automatic int take_word(int v);
    int unsigned n;
    int unsigned total;
    int j;
    int t;
    int piv;
    int f;
    int sum;
    int diff;
    longint mag;
    logic [3:0] ot;
    logic [1:0] kind;
    n = eff_n();
    total = n * (n + 1);
    if (load_cnt >= total) load_cnt = 0;
    mat[load_cnt / (n + 1)][load_cnt % (n + 1)] = v;
    load_cnt++;
    if (load_cnt < total) return 0;
    for (int i = 0; i < n; i++) begin
      if (mat[i][i] == 0) begin
        j = i + 1;
        while (j < n && mat[i][j] == 0) j++;
        if (j < n) begin
          for (int k = 0; k < n; k++) begin
            t = mat[k][i];
            mat[k][i] = mat[k][j];
            mat[k][j] = t;
          end
          ot = order[i];
          order[i] = order[j];
          order[j] = ot;
        end else begin
          for (int k = 0; k < n; k++) mat[k][i] = 0;
        end
      end
      if (mat[i][i] != 0) begin
        piv = mat[i][i];
        for (int r = 0; r < n; r++) begin
          if (r != i) begin
            f = fx_div(mat[r][i], piv);
            for (int k = 0; k <= n; k++) mat[r][k] = fx_sub(mat[r][k], fx_mul(f, mat[i][k]));
          end
        end
      end
    end
    kind = StatusDetermined;
    for (int i = n - 1; i >= 0; i--) begin
      sum = 0;
      for (int c = i + 1; c < n; c++) sum = fx_sat(longint'(sum) + fx_mul(mat[i][c], sol[c]));
      diff = fx_sub(mat[i][n], sum);
      if (mat[i][i] == 0) begin
        mag = diff < 0 ? -longint'(diff) : longint'(diff);
        if (mag < longint'(tol_reg)) begin
          sol[i] = 0;
          kind = StatusIndeterminate;
        end else begin
          kind = StatusIncompatible;
          break;
        end
      end else begin
        sol[i] = fx_div(diff, mat[i][i]);
      end
    end
    if (kind == StatusIncompatible) begin
      solved[0] = '{4'd0, 32'sd0, StatusIncompatible, 1'b1};
      restart_load();
      return 1;
    end
    for (int i = 0; i < n; i++) solved[i] = '{order[i], sol[i], kind, (i + 1 == n)};
    restart_load();
    return n;
  endfunction

  task automatic quiet();
    if (in_if.valid) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic cfg_write(logic idx, logic [15:0] v);
    quiet();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_apply(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one word in bursts; expected results are queued on acceptance.
  task automatic send_word(int v, bit typed, result_t want);
    int cnt;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data <= v;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    cnt = take_word(v);
    if (cnt > 0) systems_done++;
    if (typed && cnt > 0) pending_q.push_back(want);
    else for (int i = 0; i < cnt; i++) pending_q.push_back(solved[i]);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    quiet();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int rand_word(int unsigned kind);
    case (kind)
      0: return int'($urandom_range(0, 16'hFFFF)) + ((int'($urandom_range(0, 15)) - 8) <<< 16);
      1: return ($urandom_range(0, 1) == 0) ? 0 : rand_word(0);
      default: return int'($urandom());
    endcase
  endfunction

  function automatic void add_row(row_kind_e kind, int value, bit typed = 1'b0,
                                  result_t want = '0);
    stim_row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endfunction

  // Output handshake and comparison.
  always @(posedge clk_i) begin
    result_t got;
    result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        fail_count++;
      end else begin
        exp_res = pending_q.pop_front();
        if (got.var_num !== exp_res.var_num) begin
          $error("variable_number expected %0d got %0d", exp_res.var_num, got.var_num);
          fail_count++;
        end
        if (got.value !== exp_res.value) begin
          $error("solution_value expected %h got %h", exp_res.value, got.value);
          fail_count++;
        end
        if (got.status !== exp_res.status) begin
          $error("system_status expected %0d got %0d", exp_res.status, got.status);
          fail_count++;
        end
        if (got.last !== exp_res.last) begin
          $error("last_result expected %0d got %0d", exp_res.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off on request.
  initial begin
    int unsigned cyc;
    int unsigned mode;
    cyc = 0;
    mode = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= (cyc % 5 == 0);
      endcase
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("gauss_jordan_linear_solver regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned kind;
    int unsigned phase_no;
    int unsigned r;
    int row0[9];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    hold_req = 1'b0;
    fail_count = 0;
    words_sent = 0;
    systems_done = 0;
    results_seen = 0;
    burst_left = 3;
    size_reg = 4'd8;
    tol_reg = 16'd1;
    for (int i = 0; i < 8; i++) sol[i] = 0;
    restart_load();

    // One unknown: determined, free, inconsistent, zero tolerance, extremes.
    add_row(ROW_SIZE, 1);
    add_row(ROW_TOL, 1);
    add_row(ROW_WORD, 32'h0002_0000);
    add_row(ROW_WORD, 32'h0004_0000, 1'b1, '{4'd1, 32'sh0002_0000, StatusDetermined, 1'b1});
    add_row(ROW_WORD, 0);
    add_row(ROW_WORD, 0, 1'b1, '{4'd1, 32'sd0, StatusIndeterminate, 1'b1});
    add_row(ROW_WORD, 0);
    add_row(ROW_WORD, 32'h0005_0000, 1'b1, '{4'd0, 32'sd0, StatusIncompatible, 1'b1});
    add_row(ROW_TOL, 0);
    add_row(ROW_WORD, 0);
    add_row(ROW_WORD, 0, 1'b1, '{4'd0, 32'sd0, StatusIncompatible, 1'b1});
    add_row(ROW_TOL, 16'hFFFF);
    add_row(ROW_WORD, 32'h7FFF_FFFF);
    add_row(ROW_WORD, 32'h8000_0000);
    // A size of zero behaves as one unknown.
    add_row(ROW_SIZE, 0);
    add_row(ROW_WORD, 32'h8000_0000);
    add_row(ROW_WORD, 32'h7FFF_FFFF);
    // Two unknowns: a size write part way through restarts the load.
    add_row(ROW_SIZE, 2);
    add_row(ROW_WORD, 32'h0001_0000);
    add_row(ROW_SIZE, 2);
    // Zero pivot forces a column swap.
    add_row(ROW_WORD, 0);
    add_row(ROW_WORD, 32'h0001_0000);
    add_row(ROW_WORD, 32'h0003_0000);
    add_row(ROW_WORD, 32'h0001_0000);
    add_row(ROW_WORD, 0);
    add_row(ROW_WORD, 32'h0002_0000);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_SIZE: cfg_write(CfgSize, 16'(stim_rows[i].value));
        ROW_TOL: cfg_write(CfgTol, 16'(stim_rows[i].value));
        default: send_word(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
      endcase
      // Registers are only touched once the previous system has drained.
      if (i + 1 < stim_rows.size() && stim_rows[i + 1].kind != ROW_WORD && load_cnt == 0)
        drain();
    end

    phase_no = 0;
    while (words_sent < RandomWords + 20) begin
      drain();
      r = $urandom_range(0, 19);
      case (r)
        0: cfg_write(CfgSize, 16'd0);
        1: cfg_write(CfgSize, 16'd15);
        2: cfg_write(CfgSize, 16'd8);
        3: cfg_write(CfgSize, 16'($urandom_range(5, 7)));
        default: cfg_write(CfgSize, 16'($urandom_range(1, 4)));
      endcase
      r = $urandom_range(0, 9);
      cfg_write(CfgTol, r == 0 ? 16'd0 : r == 1 ? 16'hFFFF : 16'($urandom_range(0, 2000)));
      n = eff_n();
      if (phase_no == 2) hold_req = 1'b1;
      phase_no++;
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 11);
        if (kind == 11) begin
          // Broken load: abandoned part way by a size write.
          repeat ($urandom_range(1, n * (n + 1) - 1 + (n == 1))) send_word(rand_word(0), 0, '0);
          if (load_cnt != 0) begin
            drain();
            cfg_write(CfgSize, size_reg);
          end
          kind = 0;
        end
        if (kind >= 9) begin
          // Repeated rows give a dependent system.
          for (int c = 0; c <= n; c++) row0[c] = rand_word(0);
          for (int k = 0; k < n * (n + 1); k++) send_word(row0[k % (n + 1)], 0, '0);
        end else begin
          kind = kind < 5 ? 0 : kind < 8 ? 1 : 2;
          for (int k = 0; k < n * (n + 1); k++) send_word(rand_word(kind), 0, '0);
        end
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d expected result words never arrived", pending_q.size());
      fail_count++;
    end
    $display("Sent %0d matrix words forming %0d systems; checked %0d result words.",
             words_sent, systems_done, results_seen);
    $display("Covered swaps, free and inconsistent systems, size limits and tolerance extremes.");
    if (fail_count == 0) begin
      $display("gauss_jordan_linear_solver regression: pass");
    end else begin
      $display("gauss_jordan_linear_solver regression: fail");
    end
    $finish;
  end
endmodule

/* gauss_jordan_linear_solver.f */
+incdir+design
design/gjls_pkg.sv
design/gjls_stream_if.sv
design/gjls_ram.sv
design/gjls_divider.sv
design/gjls_datapath.sv
design/gjls_ctrl.sv
design/gauss_jordan_linear_solver.sv
design/gjls_checker.sv
tb/testbench.sv
